>>> hw/rtl/gml1_pkg.sv
package gml1_pkg;

   // field widths of the stream items
   localparam int PIXEL_W = 8;
   localparam int GRAD_W = 8;
   localparam int ROW_W = 16;
   localparam int COL_W = 11;

   // configuration register widths and reset values
   localparam int WIDTH_REG_W = 12;
   localparam int HEIGHT_REG_W = 16;
   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 12'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

   // apb port geometry
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // default line buffer depth
   localparam int DEFAULT_MAX_WIDTH = 2048;

   // saturation level of the magnitude
   localparam logic [GRAD_W-1:0] GRAD_MAX = 8'd255;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [GRAD_W-1:0] grad_type;
   typedef logic [ROW_W-1:0] row_type;
   typedef logic [COL_W-1:0] col_type;

   // register index, taken from address bit 2
   typedef enum logic {
      REG_IMAGE_WIDTH = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   // one result item
   typedef struct packed {
      grad_type gradient;
      row_type out_row;
      col_type out_col;
      logic last_of_input;
      logic frame_end;
   } result_type;

endpackage

>>> hw/rtl/gml1_if.sv
// pixel stream into the block
interface gml1_req_if
   import gml1_pkg::*;
();
   logic valid;
   logic ready;
   pixel_type pixel;

   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

// gradient result stream out of the block
interface gml1_rsp_if
   import gml1_pkg::*;
();
   logic valid;
   logic ready;
   grad_type gradient;
   row_type out_row;
   col_type out_col;
   logic last_of_input;
   logic frame_end;

   modport source (
      output valid, output gradient, output out_row, output out_col,
      output last_of_input, output frame_end, input ready
   );
   modport sink (
      input valid, input gradient, input out_row, input out_col,
      input last_of_input, input frame_end, output ready
   );
endinterface

>>> hw/rtl/gradient_magnitude_l1_stream_top.sv
// L1 gradient magnitude over a raster stream of 8-bit grey pixels.
// req_chan takes one pixel per transfer in raster order; rsp_chan gives
// one result per transfer: |dx| + |dy| saturated to 255, with the row and
// column it belongs to, a flag on the last result of each input pixel and
// a flag on the result of the frame's last pixel.
// The pixel of row r, column c yields the result of row r-1, column c; the
// first row yields nothing, the final row adds its own results one column
// behind and its last pixel adds a third result for itself.
// Each result is registered in the queue at its pixel's transfer and is
// offered behind the results already waiting. Throughput: one pixel per
// cycle while each pixel gives at most one result and the receiver takes
// it; the final row goes slower, as the output gives one result per cycle.
// The two previous rows live in one line memory of MAX_WIDTH words, read
// one column ahead with a registered read port; columns 0 and 1 are
// mirrored in registers for the wrap to a new row.
// Results wait in a four-entry queue: a pixel is taken while at most one
// result waits, so a stalled receiver holds the stream after a few
// pixels and nothing is lost. Reset clears counters, queue and bottom-row
// delays; the line memory is not cleared and needs no clearing pass.
// A register write over apb restarts the frame at row 0, column 0.
module gradient_magnitude_l1_stream_top
   import gml1_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   gml1_req_if.sink              req_chan,
   gml1_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int ColW = $clog2(MAX_WIDTH);
   localparam int QDepth = 4;
   localparam int QPtrW = $clog2(QDepth);
   localparam int QCntW = $clog2(QDepth + 1);
   localparam int NumSlots = 3;
   localparam int SlotW = $clog2(NumSlots);

   // one line memory word: row above and row two above at one column
   typedef struct packed {
      pixel_type above;
      pixel_type two_above;
   } line_word_type;

   logic [WIDTH_REG_W-1:0] width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic csr_write;
   reg_index_type csr_index;

   logic [ColW-1:0] last_col;
   row_type last_row;
   logic [ColW-1:0] col_ff, col_in;
   row_type row_ff, row_in;
   logic xfer;
   logic at_col_end, at_row_end, at_col_zero, at_col_one;

   line_word_type line_mem [MAX_WIDTH];
   line_word_type rd_word_ff;
   logic [ColW-1:0] rd_addr;
   line_word_type wr_word;
   line_word_type head0_ff, head1_ff;
   line_word_type cur_ff, cur_in;
   pixel_type prev_a_ff;
   pixel_type next_a;
   pixel_type d1_ff, d2_ff;
   pixel_type pixel;

   pixel_type main_l, main_r, main_u;
   logic main_hb, first_data_row;
   logic main_v, bl_v, cr_v;
   result_type slots [NumSlots];
   col_type out_col_cur, out_col_prev;

   result_type q_ff [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCntW-1:0] cnt_ff, cnt_in;
   logic [SlotW-1:0] push_n;
   logic [QPtrW-1:0] q_off [QDepth];
   logic q_we [QDepth];
   logic pop;

   // magnitude of one pixel: doubled one-sided differences at borders
   function automatic grad_type grad_l1(input pixel_type l, input pixel_type r,
                                        input logic hb, input pixel_type u,
                                        input pixel_type d, input logic vb);
      logic [PIXEL_W:0] dh;
      logic [PIXEL_W:0] dv;
      logic [PIXEL_W+1:0] sum;
      dh = {1'b0, (r > l) ? r - l : l - r};
      dv = {1'b0, (d > u) ? d - u : u - d};
      if (hb) begin
         dh = dh << 1;
      end
      if (vb) begin
         dv = dv << 1;
      end
      sum = {1'b0, dh} + {1'b0, dv};
      return (sum > {2'b00, GRAD_MAX}) ? GRAD_MAX : sum[GRAD_W-1:0];
   endfunction

   // apb register port
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index = reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_IMAGE_WIDTH: width_ff <= csr_pwdata[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_IMAGE_WIDTH: csr_prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default: csr_prdata = '0;
      endcase
   end

   // clamped frame geometry
   always_comb begin
      if (width_ff < WIDTH_REG_W'(2)) begin
         last_col = ColW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         last_col = ColW'(MAX_WIDTH - 1);
      end else begin
         last_col = ColW'(width_ff - WIDTH_REG_W'(1));
      end
      last_row = (height_ff < HEIGHT_REG_W'(2)) ? row_type'(1) : height_ff - row_type'(1);
   end

   // raster position
   assign pixel = req_chan.pixel;
   assign xfer = req_chan.valid & req_chan.ready;
   assign at_col_end = (col_ff == last_col);
   assign at_row_end = (row_ff == last_row);
   assign at_col_zero = (col_ff == '0);
   assign at_col_one = (col_ff == ColW'(1));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_write) begin
         col_in = '0;
         row_in = '0;
      end else if (xfer) begin
         if (at_col_end) begin
            col_in = '0;
            row_in = at_row_end ? '0 : row_ff + row_type'(1);
         end else begin
            col_in = col_ff + ColW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line memory: write the current column, read one column ahead
   assign wr_word = '{above: pixel, two_above: cur_ff.above};
   assign rd_addr = (col_in == ColW'(MAX_WIDTH - 1)) ? '0 : col_in + ColW'(1);

   always_ff @(posedge clock) begin
      if (xfer) begin
         line_mem[col_ff] <= wr_word;
      end
      rd_word_ff <= line_mem[rd_addr];
   end

   // mirrors of columns 0 and 1 for the start of a row
   always_ff @(posedge clock) begin
      if (xfer && at_col_zero) begin
         head0_ff <= wr_word;
      end
      if (xfer && at_col_one) begin
         head1_ff <= wr_word;
      end
   end

   // window on the previous rows at the current column
   always_comb begin
      cur_in = cur_ff;
      if (csr_write) begin
         cur_in = head0_ff;
      end else if (xfer) begin
         if (col_in == '0) begin
            cur_in = head0_ff;
         end else if (col_in == ColW'(1)) begin
            cur_in = head1_ff;
         end else begin
            cur_in = rd_word_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (xfer) begin
         prev_a_ff <= cur_ff.above;
      end
   end

   assign next_a = at_col_zero ? head1_ff.above : rd_word_ff.above;

   // last two pixels of the final row
   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= '0;
         d2_ff <= '0;
      end else if (xfer && at_row_end) begin
         d2_ff <= d1_ff;
         d1_ff <= pixel;
      end
   end

   // results caused by the current pixel
   assign out_col_cur = COL_W'(32'(col_ff));
   assign out_col_prev = COL_W'(32'(col_ff - ColW'(1)));

   always_comb begin
      first_data_row = (row_ff == row_type'(1));
      main_hb = at_col_zero | at_col_end;
      main_l = at_col_zero ? cur_ff.above : prev_a_ff;
      main_r = (at_col_end && !at_col_zero) ? cur_ff.above : next_a;
      main_u = first_data_row ? cur_ff.above : cur_ff.two_above;
      main_v = (row_ff != '0);
      bl_v = at_row_end && !at_col_zero;
      cr_v = at_row_end && at_col_end;

      // row above, current column
      slots[0].gradient = grad_l1(main_l, main_r, main_hb, main_u, pixel, first_data_row);
      slots[0].out_row = row_ff - row_type'(1);
      slots[0].out_col = out_col_cur;
      slots[0].last_of_input = !bl_v;
      slots[0].frame_end = 1'b0;

      // final row, previous column
      slots[1].gradient = grad_l1(at_col_one ? d1_ff : d2_ff, pixel, at_col_one,
                                  prev_a_ff, d1_ff, 1'b1);
      slots[1].out_row = row_ff;
      slots[1].out_col = out_col_prev;
      slots[1].last_of_input = !cr_v;
      slots[1].frame_end = 1'b0;

      // final row, last column
      slots[2].gradient = grad_l1(d1_ff, pixel, 1'b1, cur_ff.above, pixel, 1'b1);
      slots[2].out_row = row_ff;
      slots[2].out_col = out_col_cur;
      slots[2].last_of_input = 1'b1;
      slots[2].frame_end = 1'b1;

      push_n = '0;
      if (xfer) begin
         push_n = SlotW'(main_v) + SlotW'(bl_v) + SlotW'(cr_v);
      end
   end

   // result queue, several entries written per transfer
   assign pop = rsp_chan.valid & rsp_chan.ready;
   assign cnt_in = cnt_ff + QCntW'(push_n) - QCntW'(pop);

   always_comb begin
      for (int e = 0; e < QDepth; e++) begin
         q_off[e] = QPtrW'(e) - wr_ptr_ff;
         q_we[e] = (QCntW'(q_off[e]) < QCntW'(push_n));
      end
   end

   always_ff @(posedge clock) begin
      for (int e = 0; e < QDepth; e++) begin
         if (q_we[e]) begin
            q_ff[e] <= slots[SlotW'(q_off[e])];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + QPtrW'(push_n);
         rd_ptr_ff <= rd_ptr_ff + QPtrW'(pop);
         cnt_ff <= cnt_in;
      end
   end

   // take a pixel while room remains for its three results
   assign req_chan.ready = (cnt_ff <= QCntW'(1));

   assign rsp_chan.valid = (cnt_ff != '0);
   assign rsp_chan.gradient = q_ff[rd_ptr_ff].gradient;
   assign rsp_chan.out_row = q_ff[rd_ptr_ff].out_row;
   assign rsp_chan.out_col = q_ff[rd_ptr_ff].out_col;
   assign rsp_chan.last_of_input = q_ff[rd_ptr_ff].last_of_input;
   assign rsp_chan.frame_end = q_ff[rd_ptr_ff].frame_end;

`ifndef SYNTHESIS
   // queue never holds more than its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCntW'(QDepth))
      else $error("result queue overflow");

   // frame's last pixel gives three results
   a_last_pixel_three: assert property (@(posedge clock) disable iff (reset)
      xfer && at_row_end && at_col_end |-> push_n == SlotW'(3))
      else $error("frame end did not give three results");

   // frame's last pixel returns the counters to the frame start
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      xfer && at_row_end && at_col_end |=> row_ff == '0 && col_ff == '0)
      else $error("counters did not wrap at frame end");
`endif

endmodule
